// ===== src/cbe_pkg.sv =====
`timescale 1ns / 1ps

package cbe_pkg;

  localparam int CAPACITY_DEF = 1024;

  localparam int OP_W      = 3;
  localparam int AMT_W     = 16;
  localparam int CHAR_W    = 8;
  localparam int LEN_OUT_W = 11;
  localparam int STAT_W    = 2;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CHAR_W-1:0] FILL_CHAR = 8'h2A;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_READ    = 3'd1,
    OP_REVERSE = 3'd2,
    OP_ROT_R   = 3'd3,
    OP_ROT_L   = 3'd4,
    OP_EXTEND  = 3'd5,
    OP_SHRINK  = 3'd6,
    OP_PUT     = 3'd7
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  // which of the three reversals of a rotation is running
  typedef enum logic [1:0] {
    SEG_FIRST  = 2'd0,
    SEG_SECOND = 2'd1,
    SEG_LAST   = 2'd2
  } seg_t;

  typedef struct packed {
    logic load;
    logic app;
    logic put;
    logic shrink;
    logic rd_pos;
    logic rd_cap;
    logic rev_init;
    logic div_start;
    logic div_step;
    logic seg_first;
    logic seg_next;
    logic rd_lo;
    logic rd_hi;
    logic wr_lo;
    logic wr_hi;
    logic ext_step;
    logic set_sat;
    logic set_oor;
    logic emit;
  } cbe_cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic len_full;
    logic len_ge2;
    logic len_zero;
    logic div_last;
    logic k_zero;
    logic lo_lt_hi;
    logic phase_last;
    logic ext_done;
    logic out_free;
  } cbe_stat_t;

endpackage

// ===== src/cbe_ram.sv =====
`timescale 1ns / 1ps

module cbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cbe_datapath.sv =====
`timescale 1ns / 1ps

module cbe_datapath #(
  parameter int CAPACITY = cbe_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [cbe_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  cbe_pkg::cbe_cmd_t                  cmd,
  output cbe_pkg::cbe_stat_t                 stat,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [cbe_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int AMT_W  = cbe_pkg::AMT_W;
  localparam int CHAR_W = cbe_pkg::CHAR_W;
  localparam int CMP_W  = ((LEN_W > AMT_W) ? LEN_W : AMT_W) + 1;
  localparam int CNT_W  = $clog2(AMT_W);
  localparam int PAD_W  = cbe_pkg::OUT_TDATA_W - CHAR_W - cbe_pkg::LEN_OUT_W - cbe_pkg::STAT_W;

  cbe_pkg::op_t      op;
  cbe_pkg::seg_t     seg;
  cbe_pkg::status_t  res_stat;
  logic [AMT_W-1:0]  amt;
  logic [CHAR_W-1:0] chr;
  logic [CHAR_W-1:0] tmp;
  logic [CHAR_W-1:0] res_char;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  rem;
  logic [CNT_W-1:0]  div_cnt;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic [ADDR_W-1:0] rot_k;
  logic              out_valid;
  logic [cbe_pkg::OUT_TDATA_W-1:0] out_data;

  logic [CMP_W-1:0]  amt_x;
  logic [CMP_W-1:0]  len_x;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] len_m1;
  logic [ADDR_W-1:0] k_calc;
  logic [LEN_W:0]    trial;
  logic [LEN_W:0]    trial_sub;
  logic [LEN_W-1:0]  rem_next;
  logic [LEN_W-1:0]  shrink_len;
  logic              in_range;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CHAR_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [CHAR_W-1:0] rdata;

  assign amt_x    = CMP_W'(amt);
  assign len_x    = CMP_W'(len);
  assign in_range = (amt != '0) && (amt_x <= len_x);
  assign pos      = ADDR_W'(amt - AMT_W'(1));
  assign len_m1   = ADDR_W'(len - LEN_W'(1));

  // one restoring step of amount mod length
  assign trial     = {rem, amt[AMT_W-1]};
  assign trial_sub = trial - {1'b0, len};
  assign rem_next  = (trial >= {1'b0, len}) ? LEN_W'(trial_sub) : LEN_W'(trial);

  // rotate right by m is rotate left by length - m
  always_comb begin
    if (op == cbe_pkg::OP_ROT_R) begin
      k_calc = (rem == '0) ? '0 : ADDR_W'(len - rem);
    end else begin
      k_calc = ADDR_W'(rem);
    end
  end

  assign shrink_len = (len_x > amt_x) ? LEN_W'(len_x - amt_x) : '0;

  always_comb begin
    stat.op         = op;
    stat.in_range   = in_range;
    stat.len_full   = (len == LEN_W'(CAPACITY));
    stat.len_ge2    = (len >= LEN_W'(2));
    stat.len_zero   = (len == '0);
    stat.div_last   = (div_cnt == '0);
    stat.k_zero     = (k_calc == '0);
    stat.lo_lt_hi   = (lo < hi);
    stat.phase_last = (seg == cbe_pkg::SEG_LAST);
    stat.ext_done   = (amt == '0);
    stat.out_free   = !out_valid || m_tready;
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    if (cmd.app) begin
      we    = 1'b1;
      waddr = ADDR_W'(len);
      wdata = chr;
    end else if (cmd.put) begin
      we    = 1'b1;
      waddr = pos;
      wdata = chr;
    end else if (cmd.ext_step) begin
      we    = 1'b1;
      waddr = ADDR_W'(len);
      wdata = cbe_pkg::FILL_CHAR;
    end else if (cmd.wr_lo) begin
      we    = 1'b1;
      waddr = lo;
      wdata = rdata;
    end else if (cmd.wr_hi) begin
      we    = 1'b1;
      waddr = hi;
      wdata = tmp;
    end
    if (cmd.rd_pos) begin
      raddr = pos;
    end else if (cmd.rd_lo) begin
      raddr = lo;
    end else if (cmd.rd_hi) begin
      raddr = hi;
    end
  end

  cbe_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.app || cmd.ext_step) begin
        len <= len + LEN_W'(1);
      end else if (cmd.shrink) begin
        len <= shrink_len;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= cbe_pkg::op_t'(s_tdata[2:0]);
      amt      <= s_tdata[18:3];
      chr      <= s_tdata[26:19];
      res_char <= '0;
      res_stat <= cbe_pkg::ST_OK;
    end
    if (cmd.set_sat) begin
      res_stat <= cbe_pkg::ST_SAT;
    end
    if (cmd.set_oor) begin
      res_stat <= cbe_pkg::ST_RANGE;
    end
    if (cmd.rd_cap) begin
      res_char <= rdata;
    end
    if (cmd.div_start) begin
      rem     <= '0;
      div_cnt <= CNT_W'(AMT_W - 1);
    end
    if (cmd.div_step) begin
      rem     <= rem_next;
      amt     <= amt << 1;
      div_cnt <= div_cnt - CNT_W'(1);
    end
    if (cmd.ext_step) begin
      amt <= amt - AMT_W'(1);
    end
    if (cmd.rev_init) begin
      lo  <= '0;
      hi  <= len_m1;
      seg <= cbe_pkg::SEG_LAST;
    end
    if (cmd.seg_first) begin
      rot_k <= k_calc;
      lo    <= '0;
      hi    <= k_calc - ADDR_W'(1);
      seg   <= cbe_pkg::SEG_FIRST;
    end
    if (cmd.seg_next) begin
      hi <= len_m1;
      if (seg == cbe_pkg::SEG_FIRST) begin
        lo  <= rot_k;
        seg <= cbe_pkg::SEG_SECOND;
      end else begin
        lo  <= '0;
        seg <= cbe_pkg::SEG_LAST;
      end
    end
    if (cmd.rd_hi) begin
      tmp <= rdata;
    end
    if (cmd.wr_hi) begin
      lo <= lo + ADDR_W'(1);
      hi <= hi - ADDR_W'(1);
    end
    if (cmd.emit) begin
      out_data <= {{PAD_W{1'b0}}, res_stat, cbe_pkg::LEN_OUT_W'(len), res_char};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(CAPACITY))
    else $error("fill length above capacity");

  a_app_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.app || cmd.ext_step) |-> (len < LEN_W'(CAPACITY)))
    else $error("write past the end of the store");

  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_hi |-> (lo < hi))
    else $error("swap with crossed indices");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || m_tready))
    else $error("result overwrites one not yet taken");

endmodule

// ===== src/cbe_ctrl.sv =====
`timescale 1ns / 1ps

module cbe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  cbe_pkg::cbe_stat_t stat,
  output cbe_pkg::cbe_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_DISP = 12'b000000000010,
    S_RDW  = 12'b000000000100,
    S_DIV  = 12'b000000001000,
    S_ROT  = 12'b000000010000,
    S_CHK  = 12'b000000100000,
    S_RA   = 12'b000001000000,
    S_RB   = 12'b000010000000,
    S_RC   = 12'b000100000000,
    S_RD   = 12'b001000000000,
    S_EXT  = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_FIN;
        case (stat.op)
          cbe_pkg::OP_APPEND: begin
            if (stat.len_full) begin
              cmd.set_sat = 1'b1;
            end else begin
              cmd.app = 1'b1;
            end
          end
          cbe_pkg::OP_READ: begin
            if (stat.in_range) begin
              cmd.rd_pos = 1'b1;
              state_next = S_RDW;
            end else begin
              cmd.set_oor = 1'b1;
            end
          end
          cbe_pkg::OP_REVERSE: begin
            if (stat.len_ge2) begin
              cmd.rev_init = 1'b1;
              state_next   = S_CHK;
            end
          end
          cbe_pkg::OP_ROT_R, cbe_pkg::OP_ROT_L: begin
            if (!stat.len_zero) begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          cbe_pkg::OP_EXTEND: begin
            state_next = S_EXT;
          end
          cbe_pkg::OP_SHRINK: begin
            cmd.shrink = 1'b1;
          end
          cbe_pkg::OP_PUT: begin
            if (stat.in_range) begin
              cmd.put = 1'b1;
            end else begin
              cmd.set_oor = 1'b1;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_RDW: begin
        cmd.rd_cap = 1'b1;
        state_next = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        if (stat.k_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.seg_first = 1'b1;
          state_next    = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.lo_lt_hi) begin
          state_next = S_RA;
        end else if (stat.phase_last) begin
          state_next = S_FIN;
        end else begin
          cmd.seg_next = 1'b1;
        end
      end
      S_RA: begin
        cmd.rd_lo  = 1'b1;
        state_next = S_RB;
      end
      S_RB: begin
        cmd.rd_hi  = 1'b1;
        state_next = S_RC;
      end
      S_RC: begin
        cmd.wr_lo  = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.wr_hi  = 1'b1;
        state_next = S_CHK;
      end
      S_EXT: begin
        if (stat.ext_done) begin
          state_next = S_FIN;
        end else if (stat.len_full) begin
          cmd.set_sat = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.ext_step = 1'b1;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_DISP))
    else $error("accepted transaction not dispatched");

endmodule

// ===== src/char_buffer_edit_engine.sv =====
`timescale 1ns / 1ps

// Character buffer with in-place editing. Each transaction on the s_ side carries one command
// (append, read, reverse, rotate right/left, extend with '*', shrink, put) and produces exactly
// one result transaction on the m_ side: the character read (zero otherwise), the length after
// the command and a status (ok, position out of range and ignored, capacity saturated). The
// characters sit in a single memory with one write and one registered read port, and that port
// sets the pace. A command is taken in S_IDLE, decoded in S_DISP and handed to the output
// register in S_FIN, so the next command can be taken once the engine is back in S_IDLE. The
// command's own work comes between S_DISP and S_FIN, and S_FIN also waits while the previous
// result still sits unclaimed in the output register.
// Append, put and shrink need nothing more; a read waits for the memory in S_RDW. Reverse
// swaps pairs, each with a check, two reads and two writes (S_CHK, S_RA, S_RB, S_RC, S_RD).
// A rotation reduces the amount modulo the length by shift-subtract steps, one per amount bit,
// picks the split point in S_ROT and then, unless that point is zero, runs three reversals.
// Extend writes one fill character per cycle until the amount is used up or the buffer is
// full, when it flags saturation.
// A new command is taken only once the previous one has finished; a finished result waits in
// the output register while the next command is taken. Positions for read and put count from 1.
// The store has no reset: only positions below the current length are ever read.

module char_buffer_edit_engine #(
  parameter int CAPACITY = cbe_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // op [2:0], amount [18:3], char_in [26:19], zero [31:27]
  input  logic [cbe_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // char_out [7:0], length_now [18:8], status [20:19], zero [23:21]
  output logic [cbe_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // command strobes down, datapath flags up
  cbe_pkg::cbe_cmd_t  cmd;
  cbe_pkg::cbe_stat_t stat;

  cbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // holds the buffer, the length, the modulo unit and the output register
  cbe_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== tb/char_buffer_edit_engine_tb.sv =====
`timescale 1ns / 1ps

module char_buffer_edit_engine_tb;

  localparam int unsigned CAP        = cbe_pkg::CAPACITY_DEF;
  localparam int unsigned RAND_CMDS  = 450;
  localparam int unsigned LONG_GAP   = 60;
  localparam int unsigned LONG_STALL = 200;
  localparam int unsigned TAIL_WAIT  = 64;
  // Slowest command is a rotation of a full buffer (three reversals plus the
  // modulo pass); allow it for every command, with both sides stalling their longest.
  localparam longint unsigned CMD_CYCLES = 5 * CAP + 64 + LONG_GAP + LONG_STALL;
  localparam longint unsigned RUN_LIMIT  = (RAND_CMDS + 32) * CMD_CYCLES * 4;

  typedef struct {
    cbe_pkg::op_t op;
    logic [15:0]  amount;
    logic [7:0]   ch;
    bit           drain;   // hold this command until every result is back
  } edit_cmd_t;

  typedef struct {
    logic [7:0]       ch;
    logic [10:0]      len;
    cbe_pkg::status_t st;
  } edit_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  // op [2:0], amount [18:3], char_in [26:19], zero [31:27]
  logic [cbe_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // char_out [7:0], length_now [18:8], status [20:19], zero [23:21]
  logic [cbe_pkg::OUT_TDATA_W-1:0] m_tdata;

  edit_cmd_t    pending_cmds[$];
  edit_result_t expected_results[$];
  edit_cmd_t    in_flight;

  // shadow of the buffer, advanced once per accepted command
  logic [7:0]   buf_chars [CAP];
  int unsigned  buf_len = 0;

  // rough length seen by the stimulus generator, used only to shape the commands
  int unsigned  gen_len = 0;

  int unsigned  s_gap = 0, s_calm = 0;
  int unsigned  m_hold = 0;
  int unsigned  error_count = 0;
  longint unsigned cycle_count = 0;

  char_buffer_edit_engine #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, LONG_GAP);
  endfunction

  // Apply one command to the shadow buffer and work out its result.
  function automatic edit_result_t apply_edit(edit_cmd_t c);
    edit_result_t res;
    logic [7:0]   tmp [CAP];
    logic [7:0]   t;
    int unsigned  pos, m, room, i;
    res.ch = 8'h00;
    res.st = cbe_pkg::ST_OK;
    pos    = 32'(c.amount);
    case (c.op)
      cbe_pkg::OP_APPEND: begin
        if (buf_len < CAP) begin
          buf_chars[buf_len] = c.ch;
          buf_len++;
        end else begin
          res.st = cbe_pkg::ST_SAT;
        end
      end
      cbe_pkg::OP_READ, cbe_pkg::OP_PUT: begin
        if (pos >= 1 && pos <= buf_len) begin
          if (c.op == cbe_pkg::OP_READ) res.ch = buf_chars[pos-1];
          else buf_chars[pos-1] = c.ch;
        end else begin
          res.st = cbe_pkg::ST_RANGE;
        end
      end
      cbe_pkg::OP_REVERSE: begin
        for (i = 0; i < buf_len / 2; i++) begin
          t                       = buf_chars[i];
          buf_chars[i]            = buf_chars[buf_len-1-i];
          buf_chars[buf_len-1-i]  = t;
        end
      end
      cbe_pkg::OP_ROT_R, cbe_pkg::OP_ROT_L: begin
        if (buf_len != 0) begin
          m = pos % buf_len;
          for (i = 0; i < buf_len; i++)
            tmp[i] = (c.op == cbe_pkg::OP_ROT_R) ? buf_chars[(i + buf_len - m) % buf_len]
                                                 : buf_chars[(i + m) % buf_len];
          for (i = 0; i < buf_len; i++) buf_chars[i] = tmp[i];
        end
      end
      cbe_pkg::OP_EXTEND: begin
        // fill up to capacity; flag only when the request went past it
        room = CAP - buf_len;
        if (pos > room) begin
          res.st = cbe_pkg::ST_SAT;
          pos    = room;
        end
        for (i = 0; i < pos; i++) buf_chars[buf_len+i] = cbe_pkg::FILL_CHAR;
        buf_len += pos;
      end
      cbe_pkg::OP_SHRINK: buf_len = (buf_len > pos) ? buf_len - pos : 0;
      default: ;
    endcase
    res.len = buf_len[10:0];
    return res;
  endfunction

  function automatic void queue_cmd(cbe_pkg::op_t op, int unsigned amount, logic [7:0] ch,
                                    bit drain);
    edit_cmd_t c;
    c.op     = op;
    c.amount = amount[15:0];
    c.ch     = ch;
    c.drain  = drain;
    pending_cmds.push_back(c);
    case (op)
      cbe_pkg::OP_APPEND: if (gen_len < CAP) gen_len++;
      cbe_pkg::OP_EXTEND: gen_len = (gen_len + c.amount > CAP) ? CAP : gen_len + c.amount;
      cbe_pkg::OP_SHRINK: gen_len = (gen_len > c.amount) ? gen_len - c.amount : 0;
      default: ;
    endcase
  endfunction

  // Mostly a valid 1-based position, otherwise one just outside or anywhere.
  function automatic int unsigned pick_pos();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (gen_len != 0 && r < 80) return $urandom_range(1, gen_len);
    if (r < 87) return 0;
    if (r < 94) return gen_len + 1;
    return $urandom_range(0, 65535);
  endfunction

  // Stimulus and end of run
  initial begin
    int unsigned r, sub, amt;
    bit          drain;
    logic [7:0]  ch;

    // Empty buffer: out-of-range read and put, rotations, reversal and shrink do nothing.
    queue_cmd(cbe_pkg::OP_READ,    1,     8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_PUT,     0,     8'h55, 1'b0);
    queue_cmd(cbe_pkg::OP_ROT_R,   5,     8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_ROT_L,   0,     8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_REVERSE, 0,     8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_SHRINK,  3,     8'h00, 1'b0);
    // Single character, then a short string with the character extremes.
    queue_cmd(cbe_pkg::OP_APPEND,  0,     8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_REVERSE, 0,     8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_APPEND,  0,     8'hFF, 1'b0);
    queue_cmd(cbe_pkg::OP_APPEND,  0,     8'h5A, 1'b0);
    queue_cmd(cbe_pkg::OP_READ,    0,     8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_READ,    4,     8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_PUT,     65535, 8'hFF, 1'b0);
    queue_cmd(cbe_pkg::OP_PUT,     3,     8'h81, 1'b0);
    queue_cmd(cbe_pkg::OP_ROT_R,   65535, 8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_ROT_L,   1,     8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_READ,    2,     8'h00, 1'b0);
    // Zero extend, then extend far past capacity, then append on a full buffer.
    queue_cmd(cbe_pkg::OP_EXTEND,  0,     8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_EXTEND,  65535, 8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_APPEND,  0,     8'h7E, 1'b0);
    queue_cmd(cbe_pkg::OP_READ,    CAP,   8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_ROT_R,   CAP-1, 8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_REVERSE, 0,     8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_SHRINK,  1000,  8'h00, 1'b0);
    queue_cmd(cbe_pkg::OP_SHRINK,  65535, 8'h00, 1'b0);

    // Random part: mostly commands that do real work on a short buffer, with the odd
    // out-of-range position, huge amount or run to capacity. Drain before the first
    // random command and again half-way.
    for (int n = 0; n < RAND_CMDS; n++) begin
      drain = (n == 0 || n == RAND_CMDS / 2);
      r     = $urandom_range(0, 99);
      sub   = $urandom_range(0, 99);
      ch    = 8'($urandom_range(0, 255));
      if (gen_len > 128 && $urandom_range(0, 1) == 0) begin
        queue_cmd(cbe_pkg::OP_SHRINK, $urandom_range(gen_len / 2, gen_len + 4), ch, drain);
      end else if (r < 25) begin
        queue_cmd(cbe_pkg::OP_APPEND, $urandom_range(0, 65535), ch, drain);
      end else if (r < 45) begin
        queue_cmd(cbe_pkg::OP_READ, pick_pos(), ch, drain);
      end else if (r < 57) begin
        queue_cmd(cbe_pkg::OP_PUT, pick_pos(), ch, drain);
      end else if (r < 63) begin
        queue_cmd(cbe_pkg::OP_REVERSE, $urandom_range(0, 65535), ch, drain);
      end else if (r < 77) begin
        amt = (sub < 25) ? $urandom_range(0, 65535) : $urandom_range(0, 2 * gen_len + 1);
        queue_cmd((r < 70) ? cbe_pkg::OP_ROT_R : cbe_pkg::OP_ROT_L, amt, ch, drain);
      end else if (r < 88) begin
        if (sub < 3) amt = $urandom_range(0, 65535);
        else if (sub < 6) amt = CAP - gen_len;
        else amt = $urandom_range(0, 6);
        queue_cmd(cbe_pkg::OP_EXTEND, amt, ch, drain);
      end else begin
        amt = (sub < 5) ? 65535 : $urandom_range(0, 3);
        queue_cmd(cbe_pkg::OP_SHRINK, amt, ch, drain);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Hold until the last command is taken, then until its result is back.
    while (pending_cmds.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Command driver: predict at acceptance, then offer the next command after its gap.
  always @(posedge clk) begin
    logic                           valid_n;
    logic [cbe_pkg::IN_TDATA_W-1:0] data_n;
    valid_n = s_tvalid;
    data_n  = s_tdata;
    if (rst) begin
      valid_n = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_edit(in_flight));
        valid_n = 1'b0;
      end
      if (!valid_n) begin
        if (s_gap != 0) begin
          s_gap--;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain && expected_results.size() != 0)) begin
          in_flight = pending_cmds.pop_front();
          data_n    = {5'b0, in_flight.ch, in_flight.amount, in_flight.op};
          valid_n   = 1'b1;
          // runs of back-to-back commands between the gapped stretches
          if (s_calm != 0) begin
            s_calm--;
            s_gap = 0;
          end else begin
            s_gap = pick_gap();
            if ($urandom_range(0, 39) == 0) s_calm = $urandom_range(10, 40);
          end
        end
      end
    end
    s_tvalid <= valid_n;
    s_tdata  <= data_n;
  end

  // Result back-pressure: alternate ready runs and stalls of random length.
  always @(posedge clk) begin
    logic ready_n;
    ready_n = m_tready;
    if (rst) begin
      ready_n = 1'b0;
    end else if (m_hold != 0) begin
      m_hold--;
    end else if (m_tready) begin
      m_hold = pick_gap();
      if (m_hold != 0) begin
        ready_n = 1'b0;
        m_hold--;
      end
    end else begin
      ready_n = 1'b1;
      m_hold  = ($urandom_range(0, 39) == 0) ? $urandom_range(50, LONG_STALL)
                                             : $urandom_range(0, 6);
    end
    m_tready <= ready_n;
  end

  // Result monitor: compare each transaction with the oldest prediction.
  always @(posedge clk) begin
    edit_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, actual %h",
                 $time, m_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[7:0] !== want.ch) begin
          $display("%0t: char_out mismatch, expected %h, actual %h",
                   $time, want.ch, m_tdata[7:0]);
          error_count++;
        end
        if (m_tdata[18:8] !== want.len) begin
          $display("%0t: length_now mismatch, expected %0d, actual %0d",
                   $time, want.len, m_tdata[18:8]);
          error_count++;
        end
        if (m_tdata[20:19] !== want.st) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.st, m_tdata[20:19]);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
